/* rtl/gmd_pkg.sv */
package gmd_pkg;

  // field and register widths
  localparam int POS_W   = 12;   // non-negative pixel coordinate
  localparam int SPOS_W  = 13;   // signed input coordinate
  localparam int CS_W    = 8;    // cell edge
  localparam int DIM_W   = 13;   // image extent
  localparam int GRID_W  = 11;   // grid extent, corner limit, corner count
  localparam int MDS_W   = 16;   // squared minimum distance
  localparam int IDX_W   = 24;   // row * columns + column before range check
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;

  localparam logic [GRID_W-1:0] COUNT_MAX = 11'd1024;

  // action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_SEED  = 2'd1;
  localparam logic [1:0] ACT_CAND  = 2'd2;
  localparam logic [1:0] ACT_RSVD  = 2'd3;   // unused code, behaves as start

  // status codes
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_OUTSIDE   = 3'd1;
  localparam logic [2:0] ST_TOO_CLOSE = 3'd2;
  localparam logic [2:0] ST_LIMIT     = 3'd3;
  localparam logic [2:0] ST_SEEDED    = 3'd4;
  localparam logic [2:0] ST_SEED_OUT  = 3'd5;
  localparam logic [2:0] ST_CELL_FULL = 3'd6;
  localparam logic [2:0] ST_CLEARED   = 3'd7;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CELL_SIZE    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GRID_COLUMNS = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GRID_ROWS    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MIN_DIST_SQ  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_MAX_CORNERS  = 3'd6;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] num_x;
    logic [POS_W-1:0] num_y;
    logic [CS_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quo_x;
    logic [POS_W-1:0] quo_y;
  } div_rsp_t;

endpackage

/* rtl/grid_min_distance_feature_select.sv */
// Grid-based minimum-distance corner selection. Each input word carries one action in
// in_tuser (start, seed, candidate) and gives exactly one result word. Cell fill counts and
// stored points live in two single-port-read synchronous RAMs. After reset, and after every
// start action, a clearing pass writes zero into all GRID_CELLS fill entries, one per cycle,
// during which no input word is taken (configuration writes still are); a start shows its
// result when the pass ends. A seed and a candidate both find their cell with the 12-step
// cell divider; a candidate then walks the 3x3 neighborhood through the one RAM read port,
// reading each neighbor cell's fill (S_CELL, S_FILL) and each stored point (S_PT, S_PTD,
// S_CMP) in turn, with up to CELL_SLOTS points per cell. Limit and out-of-image rejects,
// and negative seeds, go from acceptance straight to the result state. The block is ready
// again in the same cycle that a result is posted, and the next input word is taken while
// a result still waits on out_tready.
module grid_min_distance_feature_select #(
  parameter int GRID_CELLS = 1024,
  parameter int CELL_SLOTS = 4,
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // pos_x[12:0], pos_y[25:13]
  input  logic [1:0]                  in_tuser,   // action
  // result words
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,  // out_x[11:0], out_y[23:12], corner_count[34:24]
  output logic [2:0]                  out_tuser,  // status
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [gmd_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [gmd_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int PW_    = gmd_pkg::POS_W;
  localparam int GW     = gmd_pkg::GRID_W;
  localparam int IW     = gmd_pkg::IDX_W;
  localparam int CIW    = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int FW     = $clog2(CELL_SLOTS + 1);
  localparam int PDEPTH = GRID_CELLS * CELL_SLOTS;
  localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int PTW    = 2 * COORD_BITS;
  localparam int DW     = ((COORD_BITS > PW_) ? COORD_BITS : PW_) + 1;
  localparam int SQW    = 2 * DW;
  localparam int DSW    = (SQW + 1 > 32) ? 32 : SQW + 1;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DIV   = 13'b0000000000100,
    S_IDX   = 13'b0000000001000,
    S_CELL  = 13'b0000000010000,
    S_FILL  = 13'b0000000100000,
    S_PT    = 13'b0000001000000,
    S_PTD   = 13'b0000010000000,
    S_CMP   = 13'b0000100000000,
    S_ST_RD = 13'b0001000000000,
    S_ST_WR = 13'b0010000000000,
    S_DONE  = 13'b0100000000000,
    S_SPARE = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [gmd_pkg::DIM_W-1:0] img_w_r, img_w_nxt, img_h_r, img_h_nxt;
  logic [gmd_pkg::CS_W-1:0]  cell_sz_r, cell_sz_nxt;
  logic [GW-1:0]             gcols_r, gcols_nxt, grows_r, grows_nxt;
  logic [gmd_pkg::MDS_W-1:0] mds_r, mds_nxt;
  logic [GW-1:0]             maxc_r, maxc_nxt;

  // per-item working state
  logic [1:0]     act_r, act_nxt;
  logic [PW_-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [PW_-1:0] xc_r, xc_nxt, yc_r, yc_nxt;
  logic [PW_-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [PW_-1:0] x1_r, x1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic [IW-1:0]  row_r, row_nxt, idx_r, idx_nxt;
  logic [CIW-1:0] cell_r, cell_nxt, clr_r, clr_nxt;
  logic [FW-1:0]  fill_r, fill_nxt, slot_r, slot_nxt;
  logic [SQW-1:0] sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic           report_r, report_nxt;
  logic [GW-1:0]  corners_r, corners_nxt;
  logic [2:0]     res_st_r, res_st_nxt;
  logic [PW_-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;

  // output register
  logic           out_valid_r, out_valid_nxt;
  logic [2:0]     out_user_r, out_user_nxt;
  logic [39:0]    out_data_r, out_data_nxt;

  // memory ports
  logic           fill_we;
  logic [CIW-1:0] fill_waddr, fill_raddr;
  logic [FW-1:0]  fill_wdata, fill_rdata;
  logic           pt_we;
  logic [PAW-1:0] pt_waddr, pt_raddr;
  logic [PTW-1:0] pt_wdata, pt_rdata;

  gmd_pkg::div_req_t div_req;
  gmd_pkg::div_rsp_t div_rsp;

  // input decode
  logic                        in_fire;
  logic [gmd_pkg::SPOS_W-1:0]  in_x, in_y;
  logic                        in_neg, in_outside, at_limit;
  logic [gmd_pkg::CS_W-1:0]    cs_eff;

  // neighborhood walk helpers
  logic           row_end, walk_end;
  logic [PW_-1:0] adv_cx, adv_cy;
  logic [IW-1:0]  adv_row, cidx_c, idx_c;
  state_t         adv_state;
  logic           fill_ok;

  // distance datapath
  logic [COORD_BITS-1:0] pt_x, pt_y;
  logic signed [DW-1:0]  dx_c, dy_c;
  logic signed [SQW-1:0] sqx_c, sqy_c;
  logic [SQW:0]          dfull_c;
  logic [DSW-1:0]        dist_c;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_x      = in_tdata[12:0];
  assign in_y      = in_tdata[25:13];
  assign in_neg    = in_x[gmd_pkg::SPOS_W-1] || in_y[gmd_pkg::SPOS_W-1];
  assign in_outside = in_neg || (in_x >= img_w_r) || (in_y >= img_h_r);
  assign at_limit  = (maxc_r != '0) && (corners_r >= maxc_r);
  assign cs_eff    = (cell_sz_r == '0) ? gmd_pkg::CS_W'(1) : cell_sz_r;

  assign row_end   = (cx_r == x2_r);
  assign walk_end  = row_end && (cy_r == y2_r);
  assign adv_cx    = row_end ? x1_r : cx_r + 1'b1;
  assign adv_cy    = row_end ? cy_r + 1'b1 : cy_r;
  assign adv_row   = row_end ? row_r + IW'(gcols_r) : row_r;
  assign adv_state = walk_end ? S_ST_RD : S_CELL;
  assign cidx_c    = row_r + IW'(cx_r);
  assign idx_c     = row_r + IW'(xc_r);
  assign fill_ok   = (fill_rdata < FW'(CELL_SLOTS));

  assign pt_x    = pt_rdata[COORD_BITS-1:0];
  assign pt_y    = pt_rdata[PTW-1:COORD_BITS];
  assign dx_c    = $signed(DW'(px_r)) - $signed(DW'(pt_x));
  assign dy_c    = $signed(DW'(py_r)) - $signed(DW'(pt_y));
  assign sqx_c   = dx_c * dx_c;
  assign sqy_c   = dy_c * dy_c;
  assign dfull_c = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign dist_c  = DSW'(dfull_c);   // wraps at 32 bits for wide coordinates

  always_comb begin
    state_nxt   = state_r;
    img_w_nxt   = img_w_r;
    img_h_nxt   = img_h_r;
    cell_sz_nxt = cell_sz_r;
    gcols_nxt   = gcols_r;
    grows_nxt   = grows_r;
    mds_nxt     = mds_r;
    maxc_nxt    = maxc_r;
    act_nxt     = act_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    xc_nxt      = xc_r;
    yc_nxt      = yc_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    x1_nxt      = x1_r;
    x2_nxt      = x2_r;
    y2_nxt      = y2_r;
    row_nxt     = row_r;
    idx_nxt     = idx_r;
    cell_nxt    = cell_r;
    clr_nxt     = clr_r;
    fill_nxt    = fill_r;
    slot_nxt    = slot_r;
    sqx_nxt     = sqx_r;
    sqy_nxt     = sqy_r;
    report_nxt  = report_r;
    corners_nxt = corners_r;
    res_st_nxt  = res_st_r;
    res_x_nxt   = res_x_r;
    res_y_nxt   = res_y_r;
    out_valid_nxt = out_valid_r;
    out_user_nxt  = out_user_r;
    out_data_nxt  = out_data_r;

    fill_we    = 1'b0;
    fill_waddr = idx_r[CIW-1:0];
    fill_wdata = '0;
    fill_raddr = idx_r[CIW-1:0];
    pt_we      = 1'b0;
    pt_waddr   = PAW'(idx_r[CIW-1:0]) * PAW'(CELL_SLOTS) + PAW'(fill_rdata);
    pt_wdata   = {COORD_BITS'(py_r), COORD_BITS'(px_r)};
    pt_raddr   = PAW'(cell_r) * PAW'(CELL_SLOTS) + PAW'(slot_r);

    div_req.start = 1'b0;
    div_req.num_x = in_x[PW_-1:0];
    div_req.num_y = in_y[PW_-1:0];
    div_req.den   = cs_eff;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      case (cfg_addr)
        gmd_pkg::REG_IMAGE_WIDTH:  img_w_nxt   = cfg_wdata[gmd_pkg::DIM_W-1:0];
        gmd_pkg::REG_IMAGE_HEIGHT: img_h_nxt   = cfg_wdata[gmd_pkg::DIM_W-1:0];
        gmd_pkg::REG_CELL_SIZE:    cell_sz_nxt = cfg_wdata[gmd_pkg::CS_W-1:0];
        gmd_pkg::REG_GRID_COLUMNS: gcols_nxt   = cfg_wdata[GW-1:0];
        gmd_pkg::REG_GRID_ROWS:    grows_nxt   = cfg_wdata[GW-1:0];
        gmd_pkg::REG_MIN_DIST_SQ:  mds_nxt     = cfg_wdata[gmd_pkg::MDS_W-1:0];
        gmd_pkg::REG_MAX_CORNERS:  maxc_nxt    = cfg_wdata[GW-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_r;
        fill_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == CIW'(GRID_CELLS - 1)) begin
          res_st_nxt = gmd_pkg::ST_CLEARED;
          res_x_nxt  = '0;
          res_y_nxt  = '0;
          state_nxt  = report_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          act_nxt   = in_tuser;
          px_nxt    = in_x[PW_-1:0];
          py_nxt    = in_y[PW_-1:0];
          res_x_nxt = '0;
          res_y_nxt = '0;
          case (in_tuser)
            gmd_pkg::ACT_SEED: begin
              if (corners_r < gmd_pkg::COUNT_MAX) begin
                corners_nxt = corners_r + 1'b1;
              end
              if (in_neg) begin
                res_st_nxt = gmd_pkg::ST_SEED_OUT;
                state_nxt  = S_DONE;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = S_DIV;
              end
            end
            gmd_pkg::ACT_CAND: begin
              if (at_limit) begin
                res_st_nxt = gmd_pkg::ST_LIMIT;
                state_nxt  = S_DONE;
              end else if (in_outside) begin
                res_st_nxt = gmd_pkg::ST_OUTSIDE;
                state_nxt  = S_DONE;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = S_DIV;
              end
            end
            default: begin
              // start, and the unused fourth code, empty the grid
              corners_nxt = '0;
              clr_nxt     = '0;
              report_nxt  = 1'b1;
              state_nxt   = S_CLEAR;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          xc_nxt  = div_rsp.quo_x;
          yc_nxt  = div_rsp.quo_y;
          row_nxt = IW'(div_rsp.quo_y) * IW'(gcols_r);
          if ((div_rsp.quo_x >= PW_'(gcols_r)) || (div_rsp.quo_y >= PW_'(grows_r))) begin
            res_st_nxt = (act_r == gmd_pkg::ACT_SEED) ? gmd_pkg::ST_SEED_OUT
                                                       : gmd_pkg::ST_OUTSIDE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_IDX;
          end
        end
      end
      S_IDX: begin
        idx_nxt = idx_c;
        x1_nxt  = (xc_r == '0) ? '0 : xc_r - 1'b1;
        cx_nxt  = (xc_r == '0) ? '0 : xc_r - 1'b1;
        cy_nxt  = (yc_r == '0) ? '0 : yc_r - 1'b1;
        x2_nxt  = ((13'(xc_r) + 13'd1) < 13'(gcols_r)) ? xc_r + 1'b1 : xc_r;
        y2_nxt  = ((13'(yc_r) + 13'd1) < 13'(grows_r)) ? yc_r + 1'b1 : yc_r;
        row_nxt = (yc_r == '0) ? row_r : row_r - IW'(gcols_r);
        if (idx_c >= IW'(GRID_CELLS)) begin
          res_st_nxt = (act_r == gmd_pkg::ACT_SEED) ? gmd_pkg::ST_SEED_OUT
                                                     : gmd_pkg::ST_OUTSIDE;
          state_nxt  = S_DONE;
        end else if (act_r == gmd_pkg::ACT_SEED) begin
          state_nxt = S_ST_RD;
        end else begin
          state_nxt = S_CELL;
        end
      end
      S_CELL: begin
        fill_raddr = cidx_c[CIW-1:0];
        cell_nxt   = cidx_c[CIW-1:0];
        if (cidx_c < IW'(GRID_CELLS)) begin
          state_nxt = S_FILL;
        end else begin
          // neighbor beyond the cell memory: skip
          cx_nxt    = adv_cx;
          cy_nxt    = adv_cy;
          row_nxt   = adv_row;
          state_nxt = adv_state;
        end
      end
      S_FILL: begin
        fill_nxt = fill_rdata;
        slot_nxt = '0;
        if (fill_rdata == '0) begin
          cx_nxt    = adv_cx;
          cy_nxt    = adv_cy;
          row_nxt   = adv_row;
          state_nxt = adv_state;
        end else begin
          state_nxt = S_PT;
        end
      end
      S_PT: begin
        state_nxt = S_PTD;
      end
      S_PTD: begin
        sqx_nxt   = SQW'(sqx_c);
        sqy_nxt   = SQW'(sqy_c);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        slot_nxt = slot_r + 1'b1;
        if (dist_c < DSW'(mds_r)) begin
          res_st_nxt = gmd_pkg::ST_TOO_CLOSE;
          state_nxt  = S_DONE;
        end else if (slot_r + 1'b1 == fill_r) begin
          cx_nxt    = adv_cx;
          cy_nxt    = adv_cy;
          row_nxt   = adv_row;
          state_nxt = adv_state;
        end else begin
          state_nxt = S_PT;
        end
      end
      S_ST_RD: begin
        state_nxt = S_ST_WR;
      end
      S_ST_WR: begin
        res_x_nxt = px_r;
        res_y_nxt = py_r;
        if (fill_ok) begin
          fill_we    = 1'b1;
          fill_wdata = fill_rdata + 1'b1;
          pt_we      = 1'b1;
          res_st_nxt = (act_r == gmd_pkg::ACT_SEED) ? gmd_pkg::ST_SEEDED
                                                     : gmd_pkg::ST_ACCEPTED;
        end else begin
          res_st_nxt = gmd_pkg::ST_CELL_FULL;
        end
        // seeds were counted on arrival, candidates that reach the store count here, also when the cell is full
        if ((act_r == gmd_pkg::ACT_CAND) && (corners_r < gmd_pkg::COUNT_MAX)) begin
          corners_nxt = corners_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_st_r;
          out_data_nxt  = {5'd0, corners_r, res_y_r, res_x_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      report_r    <= 1'b0;
      corners_r   <= '0;
      out_valid_r <= 1'b0;
      img_w_r     <= 13'd752;
      img_h_r     <= 13'd480;
      cell_sz_r   <= 8'd30;
      gcols_r     <= 11'd26;
      grows_r     <= 11'd16;
      mds_r       <= 16'd900;
      maxc_r      <= 11'd150;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      report_r    <= report_nxt;
      corners_r   <= corners_nxt;
      out_valid_r <= out_valid_nxt;
      img_w_r     <= img_w_nxt;
      img_h_r     <= img_h_nxt;
      cell_sz_r   <= cell_sz_nxt;
      gcols_r     <= gcols_nxt;
      grows_r     <= grows_nxt;
      mds_r       <= mds_nxt;
      maxc_r      <= maxc_nxt;
    end
    act_r      <= act_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    xc_r       <= xc_nxt;
    yc_r       <= yc_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    x1_r       <= x1_nxt;
    x2_r       <= x2_nxt;
    y2_r       <= y2_nxt;
    row_r      <= row_nxt;
    idx_r      <= idx_nxt;
    cell_r     <= cell_nxt;
    fill_r     <= fill_nxt;
    slot_r     <= slot_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    res_st_r   <= res_st_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
  end

  // fill count per cell
  gmd_ram #(.WIDTH(FW), .DEPTH(GRID_CELLS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  // stored points, CELL_SLOTS per cell
  gmd_ram #(.WIDTH(PTW), .DEPTH(PDEPTH)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  gmd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  // corner count saturates
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    corners_r <= gmd_pkg::COUNT_MAX)
    else $error("corner count beyond saturation");

  // a cell never holds more than its slots
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> (fill_wdata <= FW'(CELL_SLOTS)))
    else $error("cell fill beyond slot count");

  // point store goes with a fill increment
  a_store_pair: assert property (@(posedge clk) disable iff (!rst_n)
    pt_we |-> (fill_we && (fill_wdata == fill_rdata + 1'b1)))
    else $error("point written without fill update");

  // too close only comes from a candidate
  a_close_cand: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (res_st_r == gmd_pkg::ST_TOO_CLOSE)) |->
      (act_r == gmd_pkg::ACT_CAND))
    else $error("too-close status for a non-candidate");

  // an accepted word leaves idle at once
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second word taken while busy");

endmodule

/* rtl/gmd_ram.sv */
module gmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/gmd_div.sv */
module gmd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gmd_pkg::div_req_t  req,
  output gmd_pkg::div_rsp_t  rsp
);

  localparam int PW = gmd_pkg::POS_W;
  localparam int DW = gmd_pkg::CS_W;
  localparam int CW = $clog2(PW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW-1:0] remx_r, remx_nxt, remy_r, remy_nxt;
  logic [PW-1:0] qx_r, qx_nxt, qy_r, qy_nxt;

  // one restoring step: remainder and shifted quotient
  function automatic logic [DW+PW-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [PW-1:0] q,
                                                input logic [DW-1:0] den);
    logic [DW:0] trial;
    logic [DW:0] diff;
    begin
      trial = {rem, q[PW-1]};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
        return {diff[DW-1:0], q[PW-2:0], 1'b1};
      end else begin
        return {trial[DW-1:0], q[PW-2:0], 1'b0};
      end
    end
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    remx_nxt = remx_r;
    remy_nxt = remy_r;
    qx_nxt   = qx_r;
    qy_nxt   = qy_r;
    if (busy_r) begin
      {remx_nxt, qx_nxt} = div_step(remx_r, qx_r, den_r);
      {remy_nxt, qy_nxt} = div_step(remy_r, qy_r, den_r);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(PW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = req.den;
      remx_nxt = '0;
      remy_nxt = '0;
      qx_nxt   = req.num_x;
      qy_nxt   = req.num_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    den_r  <= den_nxt;
    remx_r <= remx_nxt;
    remy_r <= remy_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.quo_x = qx_r;
  assign rsp.quo_y = qy_r;

endmodule
